@@ hdl/foot_contact_filter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Foot contact filter assertion macros
// Shorthand for clocked, reset-qualified checks used inside the block.
// ----------------------------------------------------------------------------
`ifndef FOOT_CONTACT_FILTER_CORE_MACROS_SVH
`define FOOT_CONTACT_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Foot contact filter package
// Item types, register codes and fixed-point constants shared by the block.
// ----------------------------------------------------------------------------
package fcf_pkg;

	localparam int LEGS = 4;

	typedef enum logic [1:0] {
		KIND_FORCE  = 2'd0,
		KIND_HEIGHT = 2'd1,
		KIND_PHASE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_FORCE_THR  = 2'd0,
		REG_HEIGHT_THR = 2'd1,
		REG_ALPHA      = 2'd2
	} reg_idx_t;

	localparam logic signed [31:0] PRESS_Q16 = 32'sd1310720;
	localparam logic signed [31:0] HALF_Q16  = 32'sd32768;
	localparam logic [16:0]        ONE_Q16   = 17'd65536;

	localparam logic signed [31:0] FORCE_THR_RST  = 32'sd655360;
	localparam logic [30:0]        HEIGHT_THR_RST = 31'd1311;
	localparam logic [16:0]        ALPHA_RST      = 17'd45875;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] leg0_value;
		logic signed [31:0] leg1_value;
		logic signed [31:0] leg2_value;
		logic signed [31:0] leg3_value;
		logic signed [31:0] ground_level;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] leg0_force;
		logic signed [31:0] leg1_force;
		logic signed [31:0] leg2_force;
		logic signed [31:0] leg3_force;
		logic               leg0_contact;
		logic               leg1_contact;
		logic               leg2_contact;
		logic               leg3_contact;
	} result_t;

	// Load strobes from the pipeline control, shared by all lanes.
	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} lane_ctl_t;

	function automatic logic [LEGS-1:0][31:0] sample_values(input sample_t s);
		logic [LEGS-1:0][31:0] v;
		v[0] = s.leg0_value;
		v[1] = s.leg1_value;
		v[2] = s.leg2_value;
		v[3] = s.leg3_value;
		return v;
	endfunction

	function automatic result_t pack_result(input logic [LEGS-1:0][31:0] f,
	                                        input logic [LEGS-1:0] c);
		result_t r;
		r.leg0_force   = f[0];
		r.leg1_force   = f[1];
		r.leg2_force   = f[2];
		r.leg3_force   = f[3];
		r.leg0_contact = c[0];
		r.leg1_contact = c[1];
		r.leg2_contact = c[2];
		r.leg3_contact = c[3];
		return r;
	endfunction

endpackage

@@ hdl/fcf_lane.sv @@
// ----------------------------------------------------------------------------
// Foot contact filter lane
// Forms one leg's raw force and runs its exponential filter state.
// ----------------------------------------------------------------------------
module fcf_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  fcf_pkg::lane_ctl_t ctl,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	input  logic signed [31:0] ground,
	input  logic [30:0]        height_thr,
	input  logic [16:0]        alpha,
	output logic signed [31:0] force_val
);
	import fcf_pkg::*;

	logic signed [32:0] height_diff;
	logic [32:0]        dist_mag;
	logic               near;
	logic               low_phase;
	logic signed [31:0] raw;
	logic signed [31:0] raw_s1;
	logic signed [31:0] smoothed_q;
	logic signed [32:0] diff;
	logic signed [17:0] alpha_s;
	logic signed [50:0] prod;
	logic signed [31:0] update;

	assign height_diff = {value[31], value} - {ground[31], ground};
	assign dist_mag    = height_diff[32] ? 33'(-height_diff) : 33'(height_diff);
	assign near        = dist_mag < {2'b00, height_thr};
	assign low_phase   = value < HALF_Q16;

	always_comb begin
		case (kind_t'(kind))
			KIND_FORCE:  raw = value;
			KIND_HEIGHT: raw = near ? PRESS_Q16 : 32'sd0;
			KIND_PHASE:  raw = low_phase ? PRESS_Q16 : 32'sd0;
			default:     raw = 32'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			raw_s1 <= raw;
		end
	end

	// alpha*s + (1-alpha)*raw equals raw + alpha*(s - raw); the raw term has
	// no fraction bits, so flooring the product alone gives the same result.
	assign diff    = {smoothed_q[31], smoothed_q} - {raw_s1[31], raw_s1};
	assign alpha_s = {1'b0, alpha};
	assign prod    = alpha_s * diff;
	assign update  = raw_s1 + prod[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= 32'sd0;
		end else if (ctl.load_s2) begin
			smoothed_q <= update;
		end
	end

	assign force_val = smoothed_q;

endmodule

@@ hdl/fcf_merge.sv @@
// ----------------------------------------------------------------------------
// Foot contact filter merge stage
// Compares the lane forces with the threshold and holds the result item.
// ----------------------------------------------------------------------------
module fcf_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	input  logic [fcf_pkg::LEGS-1:0][31:0]      force_vals,
	input  logic signed [31:0]                  force_thr,
	output logic                                advance,
	output logic                                result_valid,
	input  logic                                result_ready,
	output fcf_pkg::result_t                    result
);
	import fcf_pkg::*;

	logic [LEGS-1:0] contact;
	logic            valid_q;
	result_t         result_q;

	always_comb begin
		for (int i = 0; i < LEGS; i++) begin
			contact[i] = $signed(force_vals[i]) > force_thr;
		end
	end

	assign advance = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_in) begin
			result_q <= pack_result(force_vals, contact);
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

@@ hdl/foot_contact_filter_core.sv @@
// ----------------------------------------------------------------------------
// Foot contact filter core
// Four-leg force filter and contact detector with an APB register port.
// ----------------------------------------------------------------------------
// The sample channel takes one item per cycle unless stalled: a source mode,
// one Q16.16 value per leg and the ground height. Each leg has its own lane
// that forms the raw force, then updates its exponentially filtered force.
// The result channel returns one item per sample with the four filtered
// forces and the four contact flags.
// From sample acceptance to result_valid, the raw force register loads at
// the accepting edge, the filter state register loads after it, and the
// threshold compare then lands in the output register behind result_valid.
// Throughput is one item per cycle while the receiver keeps up; the filter
// update (18 by 33 bit multiply, subtract and add) is combinational logic.
// When the receiver stalls, items keep entering until every stage is full;
// sample_ready then follows result_ready. Reset clears the filtered forces,
// empties the pipeline and loads the register defaults. Registers sit at byte
// offsets 0 (force threshold), 4 (height threshold) and 8 (alpha); the user
// must write them only while the block is idle; nothing in it enforces this.
// ----------------------------------------------------------------------------
`include "foot_contact_filter_core_macros.svh"

module foot_contact_filter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  fcf_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output fcf_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import fcf_pkg::*;

	logic signed [31:0]    force_thr_q;
	logic [30:0]           height_thr_q;
	logic [16:0]           alpha_q;
	logic [16:0]           alpha_eff_q;
	logic                  cfg_write;
	reg_idx_t              reg_idx;

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  advance_out;
	logic                  en_s1;
	logic                  en_s2;
	lane_ctl_t             lane_ctl;
	logic [LEGS-1:0][31:0] values;
	logic [LEGS-1:0][31:0] forces;

	// ---------------- register port ----------------
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_thr_q  <= FORCE_THR_RST;
			height_thr_q <= HEIGHT_THR_RST;
			alpha_q      <= ALPHA_RST;
			alpha_eff_q  <= ALPHA_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FORCE_THR:  force_thr_q  <= pwdata;
				REG_HEIGHT_THR: height_thr_q <= pwdata[30:0];
				REG_ALPHA: begin
					alpha_q <= pwdata[16:0];
					// A weight above one holds the filter, same as exactly one.
					alpha_eff_q <= (pwdata[16:0] > ONE_Q16) ? ONE_Q16 : pwdata[16:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FORCE_THR:  prdata = force_thr_q;
			REG_HEIGHT_THR: prdata = {1'b0, height_thr_q};
			REG_ALPHA:      prdata = {15'd0, alpha_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline control ----------------
	assign en_s2        = !valid_s2 || advance_out;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_ready = en_s1;

	assign lane_ctl.load_s1 = sample_valid && en_s1;
	assign lane_ctl.load_s2 = valid_s1 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= sample_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// ---------------- leg lanes ----------------
	assign values = sample_values(sample);

	for (genvar i = 0; i < LEGS; i++) begin : g_lane
		fcf_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl),
			.kind       (sample.kind),
			.value      (values[i]),
			.ground     (sample.ground_level),
			.height_thr (height_thr_q),
			.alpha      (alpha_eff_q),
			.force_val  (forces[i])
		);
	end

	// ---------------- merge and output ----------------
	fcf_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s2),
		.force_vals   (forces),
		.force_thr    (force_thr_q),
		.advance      (advance_out),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// ---------------- assertions ----------------
	`FCF_ASSERT_NOW(a_ready_only_on_stall, !sample_ready,
		result_valid && !result_ready && valid_s1 && valid_s2,
		"sample_ready low while the pipeline can still move")
	`FCF_ASSERT_NEXT(a_state_holds, !lane_ctl.load_s2, $stable(forces),
		"filter state changed without an item entering the filter stage")
	`FCF_ASSERT_NEXT(a_accept_fills_s1, sample_valid && sample_ready, valid_s1,
		"accepted item did not reach the first stage")
	`FCF_ASSERT_NEXT(a_drain_empty, result_valid && result_ready && !valid_s2, !result_valid,
		"result item appeared with no item in the filter stage")

endmodule
